// ----- design/dabc_pkg.sv -----
// Shared types and constants of the detection argmax and box clamp unit.
// No dependencies.
package dabc_pkg;

   localparam int unsigned MAX_IMAGE_DIM = 4096;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CSR_PROB_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH    = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd2;
   localparam logic [1:0] CSR_LABEL_COUNT    = 2'd3;

   typedef struct packed {
      logic               detected;
      logic               frame_done;
      logic [6:0]         class_index;
      logic [15:0]        best_prob;
      logic signed [18:0] center_x;
      logic signed [18:0] center_y;
      logic signed [18:0] box_width;
      logic signed [18:0] box_height;
   } job_type;

   function automatic logic [12:0] eff_dim(input logic [12:0] d);
      logic [12:0] r;
      if (d == 13'd0) begin
         r = 13'd1;
      end else if (32'(d) > MAX_IMAGE_DIM) begin
         r = 13'(MAX_IMAGE_DIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

// ----- design/dabc_front.sv -----
// Front part: running argmax over the class probabilities of one cell.
// Emits one job per cell that yields a result. Uses dabc_pkg.
module dabc_front #(
   parameter int unsigned MAX_CLASSES = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [15:0]         class_prob,
   input  logic                last_class,
   input  logic                last_cell,
   input  logic signed [18:0]  center_x,
   input  logic signed [18:0]  center_y,
   input  logic signed [18:0]  box_width,
   input  logic signed [18:0]  box_height,
   input  logic [15:0]         prob_threshold,
   input  logic [7:0]          label_count,
   output logic                job_push,
   output dabc_pkg::job_type   job
);

   localparam int unsigned IW   = $clog2(MAX_CLASSES);
   localparam int unsigned CW   = $clog2(MAX_CLASSES + 1);
   localparam int unsigned CMPW = (IW > 8) ? IW : 8;

   logic [15:0]   max_prob_ff, max_prob_in, new_prob;
   logic [IW-1:0] max_idx_ff, max_idx_in, new_idx;
   logic [CW-1:0] count_ff, count_in, count_next;
   logic          at_zero, at_limit, det;

   always_comb begin
      at_zero  = (count_ff == '0);
      at_limit = (count_ff == CW'(MAX_CLASSES));
      new_prob = max_prob_ff;
      new_idx  = max_idx_ff;
      if (at_zero) begin
         new_prob = class_prob;
         new_idx  = '0;
      end else if (!at_limit && (class_prob > max_prob_ff)) begin
         new_prob = class_prob;
         new_idx  = count_ff[IW-1:0];
      end
      count_next = at_limit ? count_ff : count_ff + CW'(1);

      det = (new_prob > prob_threshold) && (CMPW'(new_idx) < CMPW'(label_count));

      max_prob_in = max_prob_ff;
      max_idx_in  = max_idx_ff;
      count_in    = count_ff;
      if (accept) begin
         if (last_class) begin
            max_prob_in = '0;
            max_idx_in  = '0;
            count_in    = '0;
         end else begin
            max_prob_in = new_prob;
            max_idx_in  = new_idx;
            count_in    = count_next;
         end
      end

      job_push         = accept && last_class && (det || last_cell);
      job.detected     = det;
      job.frame_done   = last_cell;
      job.class_index  = det ? 7'(new_idx) : 7'd0;
      job.best_prob    = det ? new_prob : 16'd0;
      job.center_x     = center_x;
      job.center_y     = center_y;
      job.box_width    = box_width;
      job.box_height   = box_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_prob_ff <= '0;
         max_idx_ff  <= '0;
         count_ff    <= '0;
      end else begin
         max_prob_ff <= max_prob_in;
         max_idx_ff  <= max_idx_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ----- design/dabc_queue.sv -----
// Short job queue between the front and back parts.
// Uses dabc_pkg for the job type and depth.
module dabc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_push,
   input  dabc_pkg::job_type      wr_job,
   output logic                   wr_full,
   input  logic                   rd_pop,
   output logic                   rd_empty,
   output dabc_pkg::job_type      rd_job
);

   dabc_pkg::job_type                 slot_ff [dabc_pkg::QUEUE_DEPTH];
   logic [dabc_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dabc_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                              do_wr, do_rd;

   always_comb begin
      wr_full   = (count_ff == dabc_pkg::QUEUE_CW'(dabc_pkg::QUEUE_DEPTH));
      rd_empty  = (count_ff == '0);
      do_wr     = wr_push && !wr_full;
      do_rd     = rd_pop && !rd_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (32'(wr_ptr_ff) == dabc_pkg::QUEUE_DEPTH - 1) ? '0
                     : wr_ptr_ff + dabc_pkg::QUEUE_AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (32'(rd_ptr_ff) == dabc_pkg::QUEUE_DEPTH - 1) ? '0
                     : rd_ptr_ff + dabc_pkg::QUEUE_AW'(1);
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + dabc_pkg::QUEUE_CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - dabc_pkg::QUEUE_CW'(1);
      end
      rd_job = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ----- design/dabc_back.sv -----
// Back part: scales the box edges to pixels, truncates and clamps them.
// Two register stages, the second is the result register. Uses dabc_pkg.
module dabc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dabc_pkg::job_type      job,
   input  logic                   job_empty,
   output logic                   job_pop,
   input  logic [12:0]            image_width,
   input  logic [12:0]            image_height,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output logic                   rsp_detected,
   output logic                   rsp_frame_done,
   output logic [6:0]             rsp_class_index,
   output logic [15:0]            rsp_best_prob,
   output logic [11:0]            rsp_left_px,
   output logic [11:0]            rsp_top_px,
   output logic [11:0]            rsp_right_px,
   output logic [11:0]            rsp_bottom_px
);

   function automatic logic [11:0] clamp_px(input logic signed [34:0] p,
                                            input logic [12:0] dim);
      logic [17:0] q;
      logic [12:0] lim;
      logic [11:0] r;
      q   = p[34:17];
      lim = dim - 13'd1;
      if (p[34]) begin
         r = 12'd0;
      end else if (q > {5'd0, lim}) begin
         r = 12'(lim);
      end else begin
         r = 12'(q);
      end
      return r;
   endfunction

   logic [12:0]        dim_w, dim_h;
   logic signed [13:0] dim_w_s, dim_h_s;
   logic signed [20:0] e_left, e_top, e_right, e_bottom;

   logic               s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s1_adv, s2_adv;
   logic               s1_det_ff, s1_done_ff;
   logic [6:0]         s1_cls_ff;
   logic [15:0]        s1_prob_ff;
   logic signed [34:0] s1_left_ff, s1_top_ff, s1_right_ff, s1_bottom_ff;
   logic signed [34:0] s1_left_in, s1_top_in, s1_right_in, s1_bottom_in;

   logic               s2_det_ff, s2_done_ff;
   logic [6:0]         s2_cls_ff;
   logic [15:0]        s2_prob_ff;
   logic [11:0]        s2_left_ff, s2_top_ff, s2_right_ff, s2_bottom_ff;
   logic [11:0]        s2_left_in, s2_top_in, s2_right_in, s2_bottom_in;

   always_comb begin
      dim_w   = dabc_pkg::eff_dim(image_width);
      dim_h   = dabc_pkg::eff_dim(image_height);
      dim_w_s = $signed({1'b0, dim_w});
      dim_h_s = $signed({1'b0, dim_h});

      e_left   = $signed({job.center_x[18], job.center_x, 1'b0})
                 - $signed({{2{job.box_width[18]}}, job.box_width});
      e_right  = $signed({job.center_x[18], job.center_x, 1'b0})
                 + $signed({{2{job.box_width[18]}}, job.box_width});
      e_top    = $signed({job.center_y[18], job.center_y, 1'b0})
                 - $signed({{2{job.box_height[18]}}, job.box_height});
      e_bottom = $signed({job.center_y[18], job.center_y, 1'b0})
                 + $signed({{2{job.box_height[18]}}, job.box_height});

      s1_left_in   = e_left * dim_w_s;
      s1_right_in  = e_right * dim_w_s;
      s1_top_in    = e_top * dim_h_s;
      s1_bottom_in = e_bottom * dim_h_s;

      s2_left_in   = s1_det_ff ? clamp_px(s1_left_ff, dim_w) : 12'd0;
      s2_right_in  = s1_det_ff ? clamp_px(s1_right_ff, dim_w) : 12'd0;
      s2_top_in    = s1_det_ff ? clamp_px(s1_top_ff, dim_h) : 12'd0;
      s2_bottom_in = s1_det_ff ? clamp_px(s1_bottom_ff, dim_h) : 12'd0;

      s2_adv  = !s2_v_ff || rsp_pop;
      s1_adv  = !s1_v_ff || s2_adv;
      job_pop = s1_adv && !job_empty;
      s1_v_in = s1_adv ? !job_empty : s1_v_ff;
      s2_v_in = s2_adv ? s1_v_ff : s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_det_ff    <= job.detected;
         s1_done_ff   <= job.frame_done;
         s1_cls_ff    <= job.class_index;
         s1_prob_ff   <= job.best_prob;
         s1_left_ff   <= s1_left_in;
         s1_top_ff    <= s1_top_in;
         s1_right_ff  <= s1_right_in;
         s1_bottom_ff <= s1_bottom_in;
      end
      if (s2_adv) begin
         s2_det_ff    <= s1_det_ff;
         s2_done_ff   <= s1_done_ff;
         s2_cls_ff    <= s1_cls_ff;
         s2_prob_ff   <= s1_prob_ff;
         s2_left_ff   <= s2_left_in;
         s2_top_ff    <= s2_top_in;
         s2_right_ff  <= s2_right_in;
         s2_bottom_ff <= s2_bottom_in;
      end
   end

   assign rsp_empty       = !s2_v_ff;
   assign rsp_detected    = s2_det_ff;
   assign rsp_frame_done  = s2_done_ff;
   assign rsp_class_index = s2_cls_ff;
   assign rsp_best_prob   = s2_prob_ff;
   assign rsp_left_px     = s2_left_ff;
   assign rsp_top_px      = s2_top_ff;
   assign rsp_right_px    = s2_right_ff;
   assign rsp_bottom_px   = s2_bottom_ff;

endmodule

// ----- design/detection_argmax_box_clamp_unit.sv -----
// Top level of the detection argmax and box clamp unit: registers, front,
// job queue and back. Depends on dabc_pkg, dabc_front, dabc_queue, dabc_back.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+---------------------------
//   request  | req_* fields                  | push while full is low
//   response | rsp_* fields                  | pop while empty is low
//   csr      | csr_we, csr_index, csr_wdata  | write on csr_we, no wait
//
// One item per cycle while req_full is low; the argmax and the queue write happen in
// the cycle an item is accepted, then the job passes the multiply register and the
// clamp into the result register, where its result becomes visible.
// The two-entry job queue and the result register let either side stall alone.
// Synchronous reset clears counters, valid bits and the registers to defaults.
module detection_argmax_box_clamp_unit #(
   parameter int unsigned MAX_CLASSES = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_class_prob,
   input  logic               req_last_class,
   input  logic               req_last_cell,
   input  logic signed [18:0] req_center_x,
   input  logic signed [18:0] req_center_y,
   input  logic signed [18:0] req_box_width,
   input  logic signed [18:0] req_box_height,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_detected,
   output logic               rsp_frame_done,
   output logic [6:0]         rsp_class_index,
   output logic [15:0]        rsp_best_prob,
   output logic [11:0]        rsp_left_px,
   output logic [11:0]        rsp_top_px,
   output logic [11:0]        rsp_right_px,
   output logic [11:0]        rsp_bottom_px,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic [15:0] thr_ff, thr_in;
   logic [12:0] width_ff, width_in, height_ff, height_in;
   logic [7:0]  labels_ff, labels_in;

   logic                   accept, front_push, q_full, q_empty, q_pop;
   dabc_pkg::job_type      front_job, q_job;

   always_comb begin
      thr_in    = thr_ff;
      width_in  = width_ff;
      height_in = height_ff;
      labels_in = labels_ff;
      if (csr_we) begin
         case (csr_index)
            dabc_pkg::CSR_PROB_THRESHOLD: thr_in    = csr_wdata;
            dabc_pkg::CSR_IMAGE_WIDTH:    width_in  = csr_wdata[12:0];
            dabc_pkg::CSR_IMAGE_HEIGHT:   height_in = csr_wdata[12:0];
            dabc_pkg::CSR_LABEL_COUNT:    labels_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= 16'd32768;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         labels_ff <= 8'd80;
      end else begin
         thr_ff    <= thr_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         labels_ff <= labels_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   dabc_front #(
      .MAX_CLASSES(MAX_CLASSES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .class_prob     (req_class_prob),
      .last_class     (req_last_class),
      .last_cell      (req_last_cell),
      .center_x       (req_center_x),
      .center_y       (req_center_y),
      .box_width      (req_box_width),
      .box_height     (req_box_height),
      .prob_threshold (thr_ff),
      .label_count    (labels_ff),
      .job_push       (front_push),
      .job            (front_job)
   );

   dabc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (front_push),
      .wr_job   (front_job),
      .wr_full  (q_full),
      .rd_pop   (q_pop),
      .rd_empty (q_empty),
      .rd_job   (q_job)
   );

   dabc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job             (q_job),
      .job_empty       (q_empty),
      .job_pop         (q_pop),
      .image_width     (width_ff),
      .image_height    (height_ff),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_detected    (rsp_detected),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_class_index (rsp_class_index),
      .rsp_best_prob   (rsp_best_prob),
      .rsp_left_px     (rsp_left_px),
      .rsp_top_px      (rsp_top_px),
      .rsp_right_px    (rsp_right_px),
      .rsp_bottom_px   (rsp_bottom_px)
   );

endmodule
